// ===== hdl/mspl_pkg.sv =====
package mspl_pkg;

  localparam int ACC_W  = 68;
  localparam int GAIN_W = 24;
  localparam int CFG_W  = 31;
  localparam int IDX_W  = 3;
  localparam int CNT_W  = 5;

  localparam logic [IDX_W-1:0] REG_RPM_PER_COUNT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_KP_GAIN        = 3'd1;
  localparam logic [IDX_W-1:0] REG_KI_DT_GAIN     = 3'd2;
  localparam logic [IDX_W-1:0] REG_KD_RATE_GAIN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd5;
  localparam logic [IDX_W-1:0] REG_MAX_SPEED      = 3'd6;
  localparam logic [IDX_W-1:0] REG_PWM_FULL_SCALE = 3'd7;

  localparam logic [CNT_W-1:0] MUL_LAST = 5'd23;
  localparam logic [CNT_W-1:0] DIV_LAST = 5'd31;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_SPD,
    S_ERR,
    S_SUM,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_LIMIT,
    S_MUL_PWM,
    S_DIV_LD,
    S_DIV,
    S_OUT
  } state_t;

endpackage

// ===== hdl/mspl_if.sv =====
interface mspl_in_if #(parameter int COUNT_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COUNT_WIDTH-1:0] encoder_count;
  logic signed [15:0]            setpoint_rpm;
  modport source (output valid, encoder_count, setpoint_rpm, input ready);
  modport sink (input valid, encoder_count, setpoint_rpm, output ready);
endinterface

interface mspl_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] measured_rpm;
  logic signed [16:0] drive_rpm;
  logic        [15:0] pwm_forward;
  logic        [15:0] pwm_reverse;
  modport source (output valid, measured_rpm, drive_rpm, pwm_forward, pwm_reverse,
                  input ready);
  modport sink (input valid, measured_rpm, drive_rpm, pwm_forward, pwm_reverse,
                output ready);
endinterface

// ===== hdl/motor_speed_pid_loop.sv =====
// channel  dir  payload                                          handshake
// in_ch    in   encoder_count, setpoint_rpm                      valid/ready
// out_ch   out  measured_rpm, drive_rpm, pwm_forward, pwm_reverse valid/ready
// cfg_     in   cfg_index, cfg_wdata                             cfg_we
//
// A new request is taken only once the last result has left: five bit-serial
// multiplies on one shared shift-add unit, a restoring divider, and four
// one-state steps. out_ch.valid rises after the divider finishes. in_ch.ready
// is high only when idle.
// Reset (synchronous, rst_n low) loads register defaults and clears state.
// A stalled result holds in the output registers until out_ch.ready.
module motor_speed_pid_loop #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mspl_in_if.sink                     in_ch,
  mspl_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [mspl_pkg::IDX_W-1:0]  cfg_index,
  input  logic [mspl_pkg::CFG_W-1:0]  cfg_wdata
);
  import mspl_pkg::*;

  state_t state_r, state_nxt;

  logic [23:0] rpm_r, kp_r, ki_r, kd_r;
  logic [30:0] ilim_r;
  logic [15:0] olim_r, ms_r, pfs_r;

  logic signed [ACC_W-1:0] acc_r, a_r;
  logic        [GAIN_W-1:0] b_r;
  logic        [CNT_W-1:0]  cnt_r;
  logic signed [31:0]       err_r, last_r, sum_r;
  logic signed [15:0]       tgt_r;
  logic signed [18:0]       meas_r;
  logic signed [16:0]       drive_r;
  logic        [31:0]       q_r;
  logic        [16:0]       rem_r;
  logic signed [18:0]       o_meas_r;
  logic signed [16:0]       o_drive_r;
  logic        [15:0]       o_fwd_r, o_rev_r;

  logic mul_done, div_done;
  assign mul_done = (cnt_r == MUL_LAST);
  assign div_done = (cnt_r == DIV_LAST);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_ch.valid) state_nxt = S_MUL_SPD;
      S_MUL_SPD: if (mul_done) state_nxt = S_ERR;
      S_ERR:     state_nxt = S_SUM;
      S_SUM:     state_nxt = S_MUL_P;
      S_MUL_P:   if (mul_done) state_nxt = S_MUL_I;
      S_MUL_I:   if (mul_done) state_nxt = S_MUL_D;
      S_MUL_D:   if (mul_done) state_nxt = S_LIMIT;
      S_LIMIT:   state_nxt = S_MUL_PWM;
      S_MUL_PWM: if (mul_done) state_nxt = S_DIV_LD;
      S_DIV_LD:  state_nxt = S_DIV;
      S_DIV:     if (div_done) state_nxt = S_OUT;
      S_OUT:     if (out_ch.ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = (state_r == S_IDLE);
    out_ch.valid = (state_r == S_OUT);
  end

  assign out_ch.measured_rpm = o_meas_r;
  assign out_ch.drive_rpm    = o_drive_r;
  assign out_ch.pwm_forward  = o_fwd_r;
  assign out_ch.pwm_reverse  = o_rev_r;

  // speed / error / integral clamp / output limit / drive / divider step
  logic signed [ACC_W-1:0] spd, mt, ev, sv, lim, olim, cl, dt, msx, mag;
  logic signed [18:0] meas_c;
  logic signed [31:0] err_c, sum_c;
  logic signed [16:0] drive_c;
  logic        [16:0] rem2;
  logic               qbit;

  always_comb begin
    spd = acc_r >>> 8;
    mt  = (spd + (spd[ACC_W-1] ? ACC_W'(255) : ACC_W'(0))) >>> 8;
    if (mt > ACC_W'(262143))
      meas_c = 19'sd262143;
    else if (mt < -ACC_W'(262144))
      meas_c = -19'sd262144;
    else
      meas_c = mt[18:0];
    ev = (ACC_W'(tgt_r) <<< 8) - spd;
    if (ev > ACC_W'(33'sh0_7FFF_FFFF))
      err_c = 32'sh7FFF_FFFF;
    else if (ev < -ACC_W'(33'sh0_8000_0000))
      err_c = 32'sh8000_0000;
    else
      err_c = ev[31:0];

    lim = $signed(ACC_W'(ilim_r));
    sv  = ACC_W'(sum_r) + ACC_W'(err_r);
    if (sv > lim)
      sum_c = lim[31:0];
    else if (sv < -lim)
      sum_c = 32'(-lim);
    else
      sum_c = sv[31:0];

    olim = $signed(ACC_W'({olim_r, 24'd0}));
    if (acc_r > olim)
      cl = olim;
    else if (acc_r < -olim)
      cl = -olim;
    else
      cl = acc_r;
    dt  = (cl + (cl[ACC_W-1] ? ACC_W'(25'sh0FF_FFFF) : ACC_W'(0))) >>> 24;
    msx = $signed(ACC_W'(ms_r));
    if (dt > msx)
      drive_c = msx[16:0];
    else if (dt < -msx)
      drive_c = 17'(-msx);
    else
      drive_c = dt[16:0];
    mag = drive_r[16] ? -ACC_W'(drive_r) : ACC_W'(drive_r);

    rem2 = {rem_r[15:0], q_r[31]};
    qbit = (rem2 >= {1'b0, ms_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rpm_r   <= 24'd297891;
      kp_r    <= 24'd262144;
      ki_r    <= 24'd3277;
      kd_r    <= 24'd327680;
      ilim_r  <= 31'd17049600;
      olim_r  <= 16'd333;
      ms_r    <= 16'd333;
      pfs_r   <= 16'd3199;
      sum_r   <= '0;
      last_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_RPM_PER_COUNT:  rpm_r  <= cfg_wdata[23:0];
          REG_KP_GAIN:        kp_r   <= cfg_wdata[23:0];
          REG_KI_DT_GAIN:     ki_r   <= cfg_wdata[23:0];
          REG_KD_RATE_GAIN:   kd_r   <= cfg_wdata[23:0];
          REG_INTEGRAL_LIMIT: ilim_r <= cfg_wdata;
          REG_OUTPUT_LIMIT:   olim_r <= cfg_wdata[15:0];
          REG_MAX_SPEED:      ms_r   <= cfg_wdata[15:0];
          REG_PWM_FULL_SCALE: pfs_r  <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            a_r   <= ACC_W'(in_ch.encoder_count);
            b_r   <= rpm_r;
            tgt_r <= in_ch.setpoint_rpm;
            acc_r <= '0;
            cnt_r <= '0;
          end
        end
        S_MUL_SPD, S_MUL_P, S_MUL_I, S_MUL_D, S_MUL_PWM: begin
          acc_r <= acc_r + (b_r[0] ? a_r : '0);
          cnt_r <= mul_done ? '0 : cnt_r + 1'b1;
          if (mul_done && state_r == S_MUL_P) begin
            a_r <= ACC_W'(sum_r);
            b_r <= ki_r;
          end else if (mul_done && state_r == S_MUL_I) begin
            a_r <= ACC_W'(err_r) - ACC_W'(last_r);
            b_r <= kd_r;
          end else begin
            a_r <= a_r <<< 1;
            b_r <= b_r >> 1;
          end
          if (mul_done && state_r == S_MUL_D) last_r <= err_r;
        end
        S_ERR: begin
          meas_r <= meas_c;
          err_r  <= err_c;
        end
        S_SUM: begin
          sum_r <= sum_c;
          a_r   <= ACC_W'(err_r);
          b_r   <= kp_r;
          acc_r <= '0;
          cnt_r <= '0;
        end
        S_LIMIT: begin
          drive_r <= drive_c;
        end
        S_DIV_LD: begin
          a_r   <= mag;
          q_r   <= acc_r[31:0];
          rem_r <= '0;
          cnt_r <= '0;
        end
        S_DIV: begin
          rem_r <= qbit ? rem2 - {1'b0, ms_r} : rem2;
          q_r   <= {q_r[30:0], qbit};
          cnt_r <= div_done ? '0 : cnt_r + 1'b1;
          if (div_done) begin
            o_meas_r  <= meas_r;
            o_drive_r <= drive_r;
            o_fwd_r   <= (!drive_r[16] && drive_r != '0) ? {q_r[14:0], qbit} : '0;
            o_rev_r   <= drive_r[16] ? {q_r[14:0], qbit} : '0;
          end
        end
        default: ;
      endcase
      if (state_r == S_LIMIT) begin
        a_r   <= ACC_W'(drive_c[16] ? -ACC_W'(drive_c) : ACC_W'(drive_c));
        b_r   <= GAIN_W'(pfs_r);
        acc_r <= '0;
        cnt_r <= '0;
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("ready and valid together");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_MUL_SPD))
    else $error("request did not start multiply");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.pwm_forward == '0 || out_ch.pwm_reverse == '0))
    else $error("both pwm channels active");

endmodule

// ===== tb/mspl_tb_if.sv =====
`timescale 1ns / 100ps
// Channel interfaces come from the RTL's hdl/mspl_if.sv; this file only keeps
// the testbench's helper types next to them.
package mspl_tb_pkg;
  typedef struct packed {
    logic signed [18:0] measured_rpm;
    logic signed [16:0] drive_rpm;
    logic        [15:0] pwm_forward;
    logic        [15:0] pwm_reverse;
  } speed_result_t;
endpackage

// ===== tb/motor_speed_pid_loop_tb.sv =====
`timescale 1ns / 100ps
module motor_speed_pid_loop_tb;
  import mspl_pkg::*;
  import mspl_tb_pkg::*;

  class pid_scoreboard;
    longint rpc, kp, ki, kd, ilim, olim, maxs, pfs;
    longint err_sum, prev_err;
    speed_result_t pending[$];
    int errors;

    function new();
      rpc = 297891; kp = 262144; ki = 3277; kd = 327680;
      ilim = 17049600; olim = 333; maxs = 333; pfs = 3199;
      err_sum = 0; prev_err = 0; errors = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_RPM_PER_COUNT:  rpc  = longint'(v[23:0]);
        REG_KP_GAIN:        kp   = longint'(v[23:0]);
        REG_KI_DT_GAIN:     ki   = longint'(v[23:0]);
        REG_KD_RATE_GAIN:   kd   = longint'(v[23:0]);
        REG_INTEGRAL_LIMIT: ilim = longint'(v[30:0]);
        REG_OUTPUT_LIMIT:   olim = longint'(v[15:0]);
        REG_MAX_SPEED:      maxs = longint'(v[15:0]);
        REG_PWM_FULL_SCALE: pfs  = longint'(v[15:0]);
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function longint tdiv(longint v, int s);
      return v >= 0 ? (v >>> s) : -((-v) >>> s);
    endfunction

    function void note_request(logic signed [15:0] cnt, logic signed [15:0] tgt);
      longint spd, meas, e, drv, mag, pwm;
      longint signed acc;
      speed_result_t r;
      spd = longint'(cnt) * rpc;
      spd = spd >>> 8;
      meas = clip(tdiv(spd, 8), -262144, 262143);
      e = clip(longint'(tgt) * 256 - spd, -64'sd2147483648, 64'sd2147483647);
      err_sum = clip(err_sum + e, -ilim, ilim);
      acc = kp * e + ki * err_sum + kd * (e - prev_err);
      prev_err = e;
      acc = clip(acc, -(olim << 24), olim << 24);
      drv = clip(tdiv(acc, 24), -maxs, maxs);
      mag = drv < 0 ? -drv : drv;
      pwm = maxs == 0 ? 0 : (mag * pfs) / maxs;
      r.measured_rpm = meas[18:0];
      r.drive_rpm = drv[16:0];
      r.pwm_forward = drv > 0 ? pwm[15:0] : 16'd0;
      r.pwm_reverse = drv < 0 ? pwm[15:0] : 16'd0;
      pending.push_back(r);
    endfunction

    function void check_result(speed_result_t a);
      speed_result_t x;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %p", $time, a);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (a.measured_rpm !== x.measured_rpm) begin
        $display("%0t measured_rpm exp %0d got %0d", $time, x.measured_rpm, a.measured_rpm);
        errors++;
      end
      if (a.drive_rpm !== x.drive_rpm) begin
        $display("%0t drive_rpm exp %0d got %0d", $time, x.drive_rpm, a.drive_rpm);
        errors++;
      end
      if (a.pwm_forward !== x.pwm_forward) begin
        $display("%0t pwm_forward exp %0d got %0d", $time, x.pwm_forward, a.pwm_forward);
        errors++;
      end
      if (a.pwm_reverse !== x.pwm_reverse) begin
        $display("%0t pwm_reverse exp %0d got %0d", $time, x.pwm_reverse, a.pwm_reverse);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;
  int quiet = 0;
  pid_scoreboard sb;

  mspl_in_if #(.COUNT_WIDTH(16)) in_ch();
  mspl_out_if out_ch();

  motor_speed_pid_loop #(.COUNT_WIDTH(16)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.encoder_count = '0;
    in_ch.setpoint_rpm = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    if (hold_off || ($urandom_range(99) < recv_stall)) out_ch.ready <= 1'b0;
    else out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.measured_rpm, out_ch.drive_rpm,
                       out_ch.pwm_forward, out_ch.pwm_reverse});
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic offer_tick(logic signed [15:0] cnt, logic signed [15:0] tgt);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.encoder_count <= cnt;
    in_ch.setpoint_rpm <= tgt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(cnt, tgt);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic random_ticks(int n, bit small_vals);
    logic signed [15:0] c, t;
    for (int i = 0; i < n; i++) begin
      if (small_vals && $urandom_range(3) != 0) begin
        c = 16'(int'($urandom_range(400)) - 200);
        t = 16'(int'($urandom_range(800)) - 400);
      end else begin
        c = 16'($urandom);
        t = 16'($urandom);
      end
      offer_tick(c, t);
    end
  endtask

  task automatic random_config();
    write_reg(REG_RPM_PER_COUNT, CFG_W'($urandom_range(24'hFFFFFF)));
    write_reg(REG_KP_GAIN, CFG_W'($urandom_range(24'hFFFFFF)));
    write_reg(REG_KI_DT_GAIN, CFG_W'($urandom_range(24'hFFFFFF)));
    write_reg(REG_KD_RATE_GAIN, CFG_W'($urandom_range(24'hFFFFFF)));
    write_reg(REG_INTEGRAL_LIMIT, CFG_W'($urandom));
    write_reg(REG_OUTPUT_LIMIT, CFG_W'($urandom_range(16'hFFFF)));
    write_reg(REG_MAX_SPEED, CFG_W'($urandom_range(16'hFFFF)));
    write_reg(REG_PWM_FULL_SCALE, CFG_W'($urandom_range(16'hFFFF)));
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, extremes, saturations, zero drive
    offer_tick(16'sd0, 16'sd0);
    offer_tick(16'sd100, 16'sd300);
    offer_tick(-16'sd100, -16'sd300);
    offer_tick(16'sh7FFF, 16'sh7FFF);
    offer_tick(16'sh8000, 16'sh8000);
    offer_tick(16'sh7FFF, 16'sh8000);
    offer_tick(16'sh8000, 16'sh7FFF);
    offer_tick(-16'sd1, 16'sd0);
    drain();
    write_reg(REG_RPM_PER_COUNT, 31'hFFFFFF);
    write_reg(REG_KP_GAIN, 31'hFFFFFF);
    write_reg(REG_KI_DT_GAIN, 31'hFFFFFF);
    write_reg(REG_KD_RATE_GAIN, 31'hFFFFFF);
    write_reg(REG_INTEGRAL_LIMIT, 31'h7FFFFFFF);
    write_reg(REG_OUTPUT_LIMIT, 31'hFFFF);
    write_reg(REG_MAX_SPEED, 31'hFFFF);
    write_reg(REG_PWM_FULL_SCALE, 31'hFFFF);
    offer_tick(16'sh7FFF, 16'sh8000);
    offer_tick(16'sh8000, 16'sh7FFF);
    offer_tick(16'sh7FFF, 16'sh7FFF);
    offer_tick(16'sd0, 16'sd5);
    drain();
    write_reg(REG_MAX_SPEED, 31'd0);
    write_reg(REG_RPM_PER_COUNT, 31'd0);
    write_reg(REG_KP_GAIN, 31'd0);
    write_reg(REG_KI_DT_GAIN, 31'd0);
    write_reg(REG_KD_RATE_GAIN, 31'd0);
    write_reg(REG_INTEGRAL_LIMIT, 31'd0);
    write_reg(REG_OUTPUT_LIMIT, 31'd0);
    write_reg(REG_PWM_FULL_SCALE, 31'd0);
    offer_tick(16'sd50, 16'sd50);
    offer_tick(-16'sd50, -16'sd50);
    drain();
    write_reg(REG_KP_GAIN, 31'd262144);
    write_reg(REG_OUTPUT_LIMIT, 31'd333);
    write_reg(REG_MAX_SPEED, 31'd333);
    write_reg(REG_PWM_FULL_SCALE, 31'd3199);
    write_reg(REG_RPM_PER_COUNT, 31'd297891);
    offer_tick(16'sd10, 16'sd200);
    offer_tick(16'sd10, -16'sd200);
    drain();

    // random phases over idling modes and settings
    for (int ph = 0; ph < 8; ph++) begin
      send_idle  = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 15 : 68) : 0;
      recv_stall = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 15 : 68) : 0;
      if (ph == 2) begin
        write_reg(REG_MAX_SPEED, 31'd1);
        write_reg(REG_OUTPUT_LIMIT, 31'd2);
      end else if (ph > 2) random_config();
      random_ticks(180, ph != 5);
      drain();
    end

    // long receiver hold-off while the sender keeps offering
    send_idle = 0; recv_stall = 0;
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      random_ticks(90, 1);
    join
    drain();

    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
